// ----- rtl/mmm_pkg.sv -----
// Shared types, constants and helper functions for the motor mixer.
// Used by mmm_ctrl, mmm_datapath and multirotor_motor_mixer_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mmm_pkg;

  // Field widths
  localparam int CMD_W   = 12;  // roll / pitch / yaw amounts, signed
  localparam int THR_W   = 11;  // throttle and clamp bounds, unsigned
  localparam int DRV_W   = 11;  // drive and mixed values
  localparam int CHAN_W  = 4;   // PWM channel number
  localparam int MIDX_W  = 3;   // motor index, widest supported frame
  localparam int SUM_W   = 29;  // Q15.14 weighted sum
  localparam int PROD_W  = 28;  // pitch product
  localparam int MIX_W   = 15;  // mix after dropping fraction bits
  localparam int EMIT_W  = 17;  // desaturation arithmetic
  localparam int Q_FRAC  = 14;
  localparam int Q_ROUND = (1 << Q_FRAC) - 1;
  localparam int Q_COS30 = 14189;

  // Configuration register indexes
  localparam logic [1:0] REG_FRAME_TYPE   = 2'd0;
  localparam logic [1:0] REG_MIN_THROTTLE = 2'd1;
  localparam logic [1:0] REG_MAX_THROTTLE = 2'd2;

  // Frame codes
  localparam logic [1:0] FRAME_QUAD_X = 2'd0;
  localparam logic [1:0] FRAME_HEX_X  = 2'd1;
  localparam logic [1:0] FRAME_OCTO_X = 2'd2;

  localparam logic [THR_W-1:0] MIN_THROTTLE_RST = 11'd200;
  localparam logic [THR_W-1:0] MAX_THROTTLE_RST = 11'd1800;

  // Mixer coefficient codes: one, half, cos30 with sign, or zero
  typedef enum logic [2:0] {
    C_ZERO = 3'd0,
    C_P1   = 3'd1,
    C_N1   = 3'd2,
    C_PH   = 3'd3,
    C_NH   = 3'd4,
    C_PC   = 3'd5,
    C_NC   = 3'd6
  } coef_t;

  typedef struct packed {
    coef_t thr;
    coef_t roll;
    coef_t pitch;
    coef_t yaw;
  } coef_row_t;

  // Controller to datapath
  typedef struct packed {
    logic              load;
    logic              mix_en;
    logic [MIDX_W-1:0] mix_idx;
    logic              emit_en;
    logic [MIDX_W-1:0] emit_idx;
    logic              emit_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [MIDX_W-1:0] motor_last;
    logic              out_free;
  } status_t;

  // Motors per frame; the reserved frame code falls back to quad X
  function automatic logic [CHAN_W-1:0] frame_count(input logic [1:0] frame);
    logic [CHAN_W-1:0] n;
    unique case (frame)
      FRAME_HEX_X:  n = 4'd6;
      FRAME_OCTO_X: n = 4'd8;
      default:      n = 4'd4;
    endcase
    return n;
  endfunction

  function automatic coef_row_t mix_row(input logic [1:0] frame, input logic [MIDX_W-1:0] m);
    coef_row_t r;
    r = '{thr: C_ZERO, roll: C_ZERO, pitch: C_ZERO, yaw: C_ZERO};
    unique case (frame)
      FRAME_HEX_X: begin
        unique case (m)
          3'd0: r = '{thr: C_P1, roll: C_NH, pitch: C_PC,   yaw: C_P1};
          3'd1: r = '{thr: C_P1, roll: C_NH, pitch: C_NC,   yaw: C_P1};
          3'd2: r = '{thr: C_P1, roll: C_PH, pitch: C_PC,   yaw: C_N1};
          3'd3: r = '{thr: C_P1, roll: C_PH, pitch: C_NC,   yaw: C_N1};
          3'd4: r = '{thr: C_P1, roll: C_N1, pitch: C_ZERO, yaw: C_N1};
          3'd5: r = '{thr: C_P1, roll: C_P1, pitch: C_ZERO, yaw: C_P1};
          default: r = '{thr: C_ZERO, roll: C_ZERO, pitch: C_ZERO, yaw: C_ZERO};
        endcase
      end
      FRAME_OCTO_X: begin
        unique case (m)
          3'd0: r = '{thr: C_P1, roll: C_P1, pitch: C_NH, yaw: C_P1};
          3'd1: r = '{thr: C_P1, roll: C_NH, pitch: C_N1, yaw: C_P1};
          3'd2: r = '{thr: C_P1, roll: C_N1, pitch: C_PH, yaw: C_P1};
          3'd3: r = '{thr: C_P1, roll: C_PH, pitch: C_P1, yaw: C_P1};
          3'd4: r = '{thr: C_P1, roll: C_PH, pitch: C_N1, yaw: C_N1};
          3'd5: r = '{thr: C_P1, roll: C_N1, pitch: C_NH, yaw: C_N1};
          3'd6: r = '{thr: C_P1, roll: C_NH, pitch: C_P1, yaw: C_N1};
          default: r = '{thr: C_P1, roll: C_P1, pitch: C_PH, yaw: C_N1};
        endcase
      end
      default: begin
        unique case (m)
          3'd0: r = '{thr: C_P1, roll: C_N1, pitch: C_P1, yaw: C_N1};
          3'd1: r = '{thr: C_P1, roll: C_N1, pitch: C_N1, yaw: C_P1};
          3'd2: r = '{thr: C_P1, roll: C_P1, pitch: C_P1, yaw: C_P1};
          3'd3: r = '{thr: C_P1, roll: C_P1, pitch: C_N1, yaw: C_N1};
          default: r = '{thr: C_ZERO, roll: C_ZERO, pitch: C_ZERO, yaw: C_ZERO};
        endcase
      end
    endcase
    return r;
  endfunction

  // Weighted term for the shift-only coefficients
  function automatic logic signed [SUM_W-1:0] shift_term(input logic signed [CMD_W-1:0] x,
                                                         input coef_t c);
    logic signed [SUM_W-1:0] e;
    logic signed [SUM_W-1:0] t;
    e = SUM_W'(x);
    unique case (c)
      C_P1:    t = e <<< Q_FRAC;
      C_N1:    t = -(e <<< Q_FRAC);
      C_PH:    t = e <<< (Q_FRAC - 1);
      C_NH:    t = -(e <<< (Q_FRAC - 1));
      default: t = '0;
    endcase
    return t;
  endfunction

  // Full coefficient value, for the one axis that needs a multiplier
  function automatic logic signed [15:0] coef_value(input coef_t c);
    logic signed [15:0] v;
    unique case (c)
      C_P1:    v = 16'sd16384;
      C_N1:    v = -16'sd16384;
      C_PH:    v = 16'sd8192;
      C_NH:    v = -16'sd8192;
      C_PC:    v = 16'(Q_COS30);
      C_NC:    v = -16'(Q_COS30);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Disarmed decay: x - ceil(3x/1000); the quotient stays below eight
  function automatic logic [DRV_W-1:0] decay(input logic [DRV_W-1:0] x);
    logic [12:0] x3;
    logic [2:0]  q;
    x3 = 13'(x) + 13'(x) + 13'(x);
    q  = '0;
    for (int k = 1; k < 8; k++) begin
      if (x3 >= 13'(1000 * k - 999))
        q = q + 3'd1;
    end
    return x - DRV_W'(q);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mmm_ctrl.sv -----
// Sequencer for the motor mixer: accept, mix pass, settle, emit pass.
// Depends on mmm_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module mmm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire mmm_pkg::status_t status,
  output mmm_pkg::cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MIX  = 4'b0010,
    S_WAIT = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                    state, state_next;
  logic [mmm_pkg::MIDX_W-1:0] cnt, cnt_next;
  logic                      at_last;

  assign at_last  = (cnt == status.motor_last);
  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    cmd.load      = 1'b0;
    cmd.mix_en    = 1'b0;
    cmd.mix_idx   = cnt;
    cmd.emit_en   = 1'b0;
    cmd.emit_idx  = cnt;
    cmd.emit_last = at_last;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_MIX;
        end
      end
      S_MIX: begin
        cmd.mix_en = 1'b1;
        if (at_last) begin
          state_next = S_WAIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_WAIT: begin
        cnt_next   = '0;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_en = status.out_free;
        if (status.out_free) begin
          if (at_last) begin
            state_next = S_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mmm_datapath.sv -----
// Datapath for the motor mixer: config registers, mix pipeline, max tracking,
// desaturation, clamp, held drive values and the output register. Uses mmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmm_datapath #(
  parameter int MAX_MOTORS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [mmm_pkg::THR_W-1:0]           cfg_data,
  input  wire logic signed [mmm_pkg::CMD_W-1:0]    roll_cmd,
  input  wire logic signed [mmm_pkg::CMD_W-1:0]    pitch_cmd,
  input  wire logic signed [mmm_pkg::CMD_W-1:0]    yaw_cmd,
  input  wire logic [mmm_pkg::THR_W-1:0]           throttle_cmd,
  input  wire logic                                armed,
  input  wire logic                                out_stall,
  output logic                                     out_valid,
  output logic [mmm_pkg::CHAN_W-1:0]               motor_channel,
  output logic [mmm_pkg::DRV_W-1:0]                drive_value,
  output logic [mmm_pkg::DRV_W-1:0]                mixed_value,
  output logic                                     last_motor,
  input  wire mmm_pkg::cmd_t                       cmd,
  output mmm_pkg::status_t                         status
);

  localparam int IDX_W = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;
  localparam logic [mmm_pkg::CHAN_W-1:0] MAX_N = mmm_pkg::CHAN_W'(MAX_MOTORS);

  // Configuration
  logic [1:0]                  frame_type;
  logic [mmm_pkg::THR_W-1:0]   min_throttle;
  logic [mmm_pkg::THR_W-1:0]   max_throttle;

  // Latched input word
  logic signed [mmm_pkg::CMD_W-1:0] roll_r, pitch_r, yaw_r;
  logic [mmm_pkg::THR_W-1:0]        thr_r;
  logic                             armed_r;

  // Mix pipeline
  mmm_pkg::coef_row_t                 row;
  logic signed [mmm_pkg::CMD_W-1:0]   thr_s;
  logic signed [mmm_pkg::PROD_W-1:0]  pitch_prod;
  logic signed [mmm_pkg::SUM_W-1:0]   sum_next;
  logic signed [mmm_pkg::SUM_W-1:0]   sum_r;
  logic signed [mmm_pkg::SUM_W-1:0]   sum_adj;
  logic signed [mmm_pkg::MIX_W-1:0]   mix_q;
  logic                               sum_vld;
  logic [mmm_pkg::MIDX_W-1:0]         sum_idx;
  logic signed [mmm_pkg::MIX_W-1:0]   mixed_r [MAX_MOTORS];
  logic signed [mmm_pkg::MIX_W-1:0]   mx;

  // Emit path
  logic signed [mmm_pkg::EMIT_W-1:0]  lo_s, hi_s, mx_e, excess, v_sub, v_clamp;
  logic [mmm_pkg::DRV_W-1:0]          mixed_out, held_sel, drive_new;
  logic [mmm_pkg::DRV_W-1:0]          held_drive [MAX_MOTORS];
  logic [IDX_W-1:0]                   emit_i;
  logic [mmm_pkg::CHAN_W-1:0]         motor_n;

  // Motor count of the selected frame, capped by the build
  always_comb begin
    motor_n = mmm_pkg::frame_count(frame_type);
    if (motor_n > MAX_N)
      motor_n = MAX_N;
  end

  assign status.motor_last = mmm_pkg::MIDX_W'(motor_n - 4'd1);
  assign status.out_free   = !out_valid || !out_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_type   <= mmm_pkg::FRAME_QUAD_X;
      min_throttle <= mmm_pkg::MIN_THROTTLE_RST;
      max_throttle <= mmm_pkg::MAX_THROTTLE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mmm_pkg::REG_FRAME_TYPE:   frame_type   <= cfg_data[1:0];
        mmm_pkg::REG_MIN_THROTTLE: min_throttle <= cfg_data;
        mmm_pkg::REG_MAX_THROTTLE: max_throttle <= cfg_data;
        default: ;
      endcase
    end
  end

  // Latch the input word on accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      roll_r  <= roll_cmd;
      pitch_r <= pitch_cmd;
      yaw_r   <= yaw_cmd;
      thr_r   <= throttle_cmd;
      armed_r <= armed;
    end
  end

  // Stage one: weighted sum for one motor
  always_comb begin
    row        = mmm_pkg::mix_row(frame_type, cmd.mix_idx);
    thr_s      = $signed({1'b0, thr_r});
    pitch_prod = mmm_pkg::PROD_W'(pitch_r) * mmm_pkg::PROD_W'(mmm_pkg::coef_value(row.pitch));
    sum_next   = mmm_pkg::shift_term(thr_s, row.thr)
               + mmm_pkg::shift_term(roll_r, row.roll)
               + mmm_pkg::SUM_W'(pitch_prod)
               + mmm_pkg::shift_term(yaw_r, row.yaw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= 1'b0;
    end else begin
      sum_vld <= cmd.mix_en;
    end
  end

  always_ff @(posedge clk) begin
    sum_r   <= sum_next;
    sum_idx <= cmd.mix_idx;
  end

  // Stage two: drop the fraction toward zero, store, track the largest mix
  always_comb begin
    sum_adj = sum_r + (sum_r[mmm_pkg::SUM_W-1] ? mmm_pkg::SUM_W'(mmm_pkg::Q_ROUND)
                                                : mmm_pkg::SUM_W'(0));
    mix_q   = mmm_pkg::MIX_W'(sum_adj >>> mmm_pkg::Q_FRAC);
  end

  always_ff @(posedge clk) begin
    if (sum_vld) begin
      mixed_r[sum_idx[IDX_W-1:0]] <= mix_q;
      if (sum_idx == '0 || mix_q > mx)
        mx <= mix_q;
    end
  end

  // Desaturate and clamp the selected motor, then decay or take it
  always_comb begin
    emit_i = cmd.emit_idx[IDX_W-1:0];
    lo_s   = mmm_pkg::EMIT_W'($signed({1'b0, min_throttle}));
    hi_s   = mmm_pkg::EMIT_W'($signed({1'b0, max_throttle}));
    mx_e   = mmm_pkg::EMIT_W'(mx);
    excess = (mx_e > hi_s) ? (mx_e - hi_s) : '0;
    v_sub  = mmm_pkg::EMIT_W'(mixed_r[emit_i]) - excess;
    priority if (v_sub < lo_s) begin
      v_clamp = lo_s;
    end else if (v_sub > hi_s) begin
      v_clamp = hi_s;
    end else begin
      v_clamp = v_sub;
    end
    mixed_out = v_clamp[mmm_pkg::DRV_W-1:0];
    held_sel  = held_drive[emit_i];
    drive_new = armed_r ? mixed_out : mmm_pkg::decay(held_sel);
  end

  // Held drive values
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_MOTORS; i++)
        held_drive[i] <= '0;
    end else if (cmd.emit_en) begin
      held_drive[emit_i] <= drive_new;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_en) begin
      motor_channel <= mmm_pkg::CHAN_W'(cmd.emit_idx) + 4'd1;
      drive_value   <= drive_new;
      mixed_value   <= mixed_out;
      last_motor    <= cmd.emit_last;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/multirotor_motor_mixer_top.sv -----
// Top level of the multirotor motor mixer: joins controller and datapath.
// Depends on mmm_pkg, mmm_ctrl and mmm_datapath.
//
//   channel  direction  handshake             word
//   in       in         in_valid / in_stall   roll, pitch, yaw, throttle, armed
//   out      out        out_valid / out_stall one motor: channel, drive, mix, last
//   cfg      in         cfg_write             cfg_index, cfg_data
//
// An input word for an N-motor frame passes one motor per cycle through the mix
// pipeline, then a settle state, then one motor per cycle (while the output is
// not stalled) through the emit path into the output register.
// Reset (rst, synchronous) restores the default config and zeroes held drives.
// A stall on the output holds the emit pass; the next input word is taken
// while the last motor word still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module multirotor_motor_mixer_top #(
  parameter int MAX_MOTORS = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [mmm_pkg::THR_W-1:0]        cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [mmm_pkg::CMD_W-1:0] roll_cmd,
  input  wire logic signed [mmm_pkg::CMD_W-1:0] pitch_cmd,
  input  wire logic signed [mmm_pkg::CMD_W-1:0] yaw_cmd,
  input  wire logic [mmm_pkg::THR_W-1:0]        throttle_cmd,
  input  wire logic                             armed,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [mmm_pkg::CHAN_W-1:0]            motor_channel,
  output logic [mmm_pkg::DRV_W-1:0]             drive_value,
  output logic [mmm_pkg::DRV_W-1:0]             mixed_value,
  output logic                                  last_motor
);

  mmm_pkg::cmd_t    cmd;
  mmm_pkg::status_t status;

  mmm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mmm_datapath #(
    .MAX_MOTORS (MAX_MOTORS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .roll_cmd      (roll_cmd),
    .pitch_cmd     (pitch_cmd),
    .yaw_cmd       (yaw_cmd),
    .throttle_cmd  (throttle_cmd),
    .armed         (armed),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .motor_channel (motor_channel),
    .drive_value   (drive_value),
    .mixed_value   (mixed_value),
    .last_motor    (last_motor),
    .cmd           (cmd),
    .status        (status)
  );

  // Accepting a word starts a pass, so the next cycle must stall
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a pass was running");

  // Emit and load never overlap
  a_no_load_in_emit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.emit_en))
    else $error("load and emit in the same cycle");

  // The flagged last word carries the frame's highest channel
  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_en && cmd.emit_last |=>
      motor_channel == mmm_pkg::CHAN_W'(status.motor_last) + 4'd1)
    else $error("last motor flag on wrong channel");

  // Within a pass, a taken word that is not the last is replaced at once
  a_emit_back_to_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_motor |=> out_valid)
    else $error("gap inside an emit pass");

endmodule

`default_nettype wire
